[hw/rtl/bra_pkg.sv]
package bra_pkg;

  // Map geometry
  localparam int MAP_BYTES_MAX_DEF = 512;
  localparam int WORD_W            = 64;
  localparam int WORD_BITS_W       = 6;    // log2 of WORD_W
  localparam int CFG_W             = 10;   // map_bytes register
  localparam int BIT_CNT_W         = 13;   // bit counts up to 1023*8
  localparam int SCAN_WORD_W       = 7;    // words reachable by a 10-bit byte count

  localparam logic [CFG_W-1:0] MAP_BYTES_RESET = 10'd512;

  // Request modes
  localparam logic [2:0] MODE_TEST      = 3'd0;
  localparam logic [2:0] MODE_SET       = 3'd1;
  localparam logic [2:0] MODE_CLR       = 3'd2;
  localparam logic [2:0] MODE_SCAN      = 3'd3;
  localparam logic [2:0] MODE_CLEAR_ALL = 3'd4;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_NONE  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [11:0] bit_index;
    logic [12:0] run_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        bit_value;
    logic [11:0] start_index;
  } rsp_t;

  // Per-word scan outcome
  typedef struct packed {
    logic                 hit;
    logic [BIT_CNT_W-1:0] start;
    logic [BIT_CNT_W-1:0] run;
  } scan_res_t;

endpackage

[hw/rtl/bitmap_run_allocator_core.sv]
// First-fit bitmap allocator core.
// Requests arrive on in_* (valid/stall); one result leaves on out_* per request.
// A request is taken when in_valid_i is high and in_stall_o is low; in_stall_o
// stays high from the cycle after acceptance until the result has moved into
// the output register, so one request is worked on at a time.
// Test/set/clear read the addressed word of the map RAM, and set/clear write
// it back. A scan reads the map one 64-bit word per cycle from word 0 and
// stops at the word where a long enough free run is found or at the last
// word of the map (a full 4096-bit map is 64 words). Clear-all writes one
// zero word per cycle, WORDS words in all, where WORDS = ceil(MAP_BYTES_MAX / 8).
// The map is not touched when the index is out of range, for a zero-length
// scan, a scan of an empty map or an unused mode. The next request can be
// taken as soon as the result has moved into the output register.
// The output register holds its result while out_stall_i is high; a new
// request may be accepted meanwhile and waits for that register to free up.
// After reset the block sweeps zeros into all WORDS words of the map RAM with
// in_stall_o high, then accepts requests. map_bytes resets to 512; it is written
// through cfg_we_i / cfg_wdata_i; the user must do so only while idle, as the block does not enforce it.
module bitmap_run_allocator_core #(
  parameter int MAP_BYTES_MAX = bra_pkg::MAP_BYTES_MAX_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bra_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bra_pkg::req_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bra_pkg::rsp_t              out_data_o
);
  import bra_pkg::*;

  localparam int WORDS  = (MAP_BYTES_MAX + 7) / 8;
  localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORDS - 1);
  localparam logic [CFG_W-1:0]  MAX_CLIP  =
    (MAP_BYTES_MAX > 1023) ? 10'd1023 : CFG_W'(MAP_BYTES_MAX);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DISP  = 6'b000100,
    S_BIT   = 6'b001000,
    S_SCAN  = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  map_bytes_q;
  logic [ADDR_W-1:0] clr_ptr_q, clr_ptr_d;
  logic              clr_resp_q, clr_resp_d;
  logic [ADDR_W-1:0] word_q, word_d;
  logic [BIT_CNT_W-1:0] run_q, run_d;
  req_t              req_q, req_d;
  rsp_t              res_q, res_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_data_q, out_data_d;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // Map size in use
  logic [CFG_W-1:0]       eff_bytes;
  logic [BIT_CNT_W-1:0]   nbits;
  logic [CFG_W:0]         bytes_round;
  logic [7:0]             last_word8;
  logic [ADDR_W-1:0]      last_word;
  logic                   idx_ok;
  logic [ADDR_W-1:0]      bit_word;
  logic [WORD_W-1:0]      bit_onehot;

  assign eff_bytes   = (map_bytes_q > MAX_CLIP) ? MAX_CLIP : map_bytes_q;
  assign nbits       = {eff_bytes, 3'b000};
  assign bytes_round = {1'b0, eff_bytes} + (CFG_W+1)'(7);
  assign last_word8  = bytes_round[CFG_W:3] - 8'd1;
  assign last_word   = ADDR_W'(last_word8);
  assign idx_ok      = {1'b0, req_q.bit_index} < nbits;
  assign bit_word    = ADDR_W'(req_q.bit_index[11:WORD_BITS_W]);
  assign bit_onehot  = WORD_W'(1) << req_q.bit_index[WORD_BITS_W-1:0];

  // Scan word: free mask with bits past the map end treated as used
  logic                 is_last;
  logic [WORD_W-1:0]    tail_mask;
  logic [WORD_W-1:0]    free_word;
  logic [BIT_CNT_W-1:0] base_bit;
  scan_res_t            scan;

  assign is_last   = (word_q == last_word);
  assign tail_mask = (is_last && (eff_bytes[2:0] != 3'd0))
                   ? ((WORD_W'(1) << {eff_bytes[2:0], 3'b000}) - WORD_W'(1)) : '1;
  assign free_word = ~ram_rdata & tail_mask;
  assign base_bit  = {SCAN_WORD_W'(word_q), WORD_BITS_W'(0)};

  bra_scan u_scan (
    .free_i (free_word),
    .run_i  (run_q),
    .len_i  (req_q.run_length),
    .base_i (base_bit),
    .res_o  (scan)
  );

  bra_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_ptr_d   = clr_ptr_q;
    clr_resp_d  = clr_resp_q;
    word_d      = word_q;
    run_d       = run_q;
    req_d       = req_q;
    res_d       = res_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = clr_ptr_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_ptr_q == LAST_ADDR) begin
          clr_ptr_d = '0;
          if (clr_resp_q) begin
            clr_resp_d = 1'b0;
            res_d      = '{status: STATUS_OK, bit_value: 1'b0, start_index: '0};
            state_d    = S_RESP;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          clr_ptr_d = clr_ptr_q + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (req_q.mode)
          MODE_TEST, MODE_SET, MODE_CLR: begin
            if (idx_ok) begin
              ram_re    = 1'b1;
              ram_raddr = bit_word;
              state_d   = S_BIT;
            end else begin
              res_d   = '{status: STATUS_RANGE, bit_value: 1'b0, start_index: '0};
              state_d = S_RESP;
            end
          end
          MODE_SCAN: begin
            if ((req_q.run_length == '0) || (eff_bytes == '0)) begin
              res_d   = '{status: STATUS_NONE, bit_value: 1'b0, start_index: '0};
              state_d = S_RESP;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              word_d    = '0;
              run_d     = '0;
              state_d   = S_SCAN;
            end
          end
          MODE_CLEAR_ALL: begin
            clr_resp_d = 1'b1;
            state_d    = S_CLEAR;
          end
          default: begin
            res_d   = '{status: STATUS_OK, bit_value: 1'b0, start_index: '0};
            state_d = S_RESP;
          end
        endcase
      end
      S_BIT: begin
        // read of the addressed word, written back modified for set and clear
        ram_waddr = bit_word;
        if (req_q.mode == MODE_SET) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | bit_onehot;
        end else if (req_q.mode == MODE_CLR) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~bit_onehot;
        end
        res_d = '{status:      STATUS_OK,
                  bit_value:   (req_q.mode == MODE_TEST) &
                               ram_rdata[req_q.bit_index[WORD_BITS_W-1:0]],
                  start_index: '0};
        state_d = S_RESP;
      end
      S_SCAN: begin
        if (scan.hit) begin
          res_d   = '{status: STATUS_OK, bit_value: 1'b0, start_index: scan.start[11:0]};
          state_d = S_RESP;
        end else if (is_last) begin
          res_d   = '{status: STATUS_NONE, bit_value: 1'b0, start_index: '0};
          state_d = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = word_q + ADDR_W'(1);
          word_d    = word_q + ADDR_W'(1);
          run_d     = scan.run;
        end
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_ptr_q   <= '0;
      clr_resp_q  <= 1'b0;
      word_q      <= '0;
      out_valid_q <= 1'b0;
      map_bytes_q <= MAP_BYTES_RESET;
    end else begin
      state_q     <= state_d;
      clr_ptr_q   <= clr_ptr_d;
      clr_resp_q  <= clr_resp_d;
      word_q      <= word_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        map_bytes_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    res_q      <= res_d;
    run_q      <= run_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[hw/rtl/bra_ram.sv]
module bra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bra_scan.sv]
module bra_scan (
  input  logic [bra_pkg::WORD_W-1:0]    free_i,   // 1 = free, tail beyond map forced to 0
  input  logic [bra_pkg::BIT_CNT_W-1:0] run_i,    // free run ending just below this word
  input  logic [bra_pkg::BIT_CNT_W-1:0] len_i,    // wanted run length, nonzero
  input  logic [bra_pkg::BIT_CNT_W-1:0] base_i,   // bit address of bit 0 of this word
  output bra_pkg::scan_res_t            res_o
);
  import bra_pkg::*;

  // Count of free bits from bit 0 upward
  function automatic logic [WORD_BITS_W:0] trail_free(input logic [WORD_W-1:0] f);
    logic [WORD_BITS_W:0] c;
    c = (WORD_BITS_W+1)'(WORD_W);
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (!f[j]) c = (WORD_BITS_W+1)'(j);
    end
    return c;
  endfunction

  // Count of free bits from the top bit downward
  function automatic logic [WORD_BITS_W:0] lead_free(input logic [WORD_W-1:0] f);
    logic [WORD_BITS_W:0] c;
    c = (WORD_BITS_W+1)'(WORD_W);
    for (int j = 0; j < WORD_W; j++) begin
      if (!f[j]) c = (WORD_BITS_W+1)'(WORD_W - 1 - j);
    end
    return c;
  endfunction

  // Bit s set when bits s .. s+n-1 are all free inside the word
  function automatic logic [WORD_W-1:0] run_mask(input logic [WORD_W-1:0] f,
                                                 input logic [WORD_BITS_W-1:0] n);
    logic [WORD_W-1:0]      pw;
    logic [WORD_W-1:0]      h;
    logic [WORD_BITS_W-1:0] off;
    pw  = f;
    h   = '1;
    off = '0;
    for (int b = 0; b < WORD_BITS_W; b++) begin
      if (n[b]) begin
        h   = h & (pw >> off);
        off = off + WORD_BITS_W'(1 << b);
      end
      pw = pw & (pw >> (1 << b));
    end
    return h;
  endfunction

  function automatic logic [WORD_BITS_W-1:0] lowest_one(input logic [WORD_W-1:0] h);
    logic [WORD_BITS_W-1:0] p;
    p = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (h[j]) p = WORD_BITS_W'(j);
    end
    return p;
  endfunction

  logic [WORD_BITS_W:0]   tz;
  logic [WORD_BITS_W:0]   lz;
  logic [BIT_CNT_W:0]     prefix_sum;
  logic                   prefix_hit;
  logic                   short_len;
  logic [WORD_W-1:0]      inner;
  logic [WORD_BITS_W-1:0] inner_pos;
  logic [BIT_CNT_W:0]     run_plus;

  assign tz         = trail_free(free_i);
  assign lz         = lead_free(free_i);
  assign prefix_sum = {1'b0, run_i} + (BIT_CNT_W+1)'(tz);
  // Carried run plus the free bits at the bottom reach the length
  assign prefix_hit = prefix_sum >= {1'b0, len_i};

  // Runs that start inside this word and end inside it
  assign short_len  = (len_i[BIT_CNT_W-1:WORD_BITS_W] == '0);
  assign inner      = short_len ? run_mask(free_i, len_i[WORD_BITS_W-1:0]) : '0;
  assign inner_pos  = lowest_one(inner);
  assign run_plus   = {1'b0, run_i} + (BIT_CNT_W+1)'(WORD_W);

  always_comb begin
    res_o.hit   = prefix_hit | (|inner);
    res_o.start = prefix_hit ? (base_i - run_i) : (base_i + BIT_CNT_W'(inner_pos));
    res_o.run   = (&free_i) ? run_plus[BIT_CNT_W-1:0] : BIT_CNT_W'(lz);
  end

endmodule

[hw/rtl/bra_checker.sv]
module bra_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input bra_pkg::rsp_t out_data_o
);
  import bra_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed under stall");

  // One request at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request channel not stalled after acceptance");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == STATUS_OK) ||
                    (out_data_o.status == STATUS_NONE) ||
                    (out_data_o.status == STATUS_RANGE))
    else $error("undefined status code");

  a_bit_value_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bit_value |-> out_data_o.status == STATUS_OK)
    else $error("bit value set on a failed request");

  a_start_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STATUS_OK) |-> out_data_o.start_index == '0)
    else $error("nonzero start on a failed request");

endmodule

bind bitmap_run_allocator_core bra_checker u_bra_checker (.*);
